FILE: hw/rtl/ptftd_pkg.sv
// Shared types, codes and defaults for the per-task fractional tick divider.
package ptftd_pkg;

  localparam int NUM_TASKS_DEF    = 8;
  localparam int BASE_FREQ_HZ_DEF = 1024;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int MS_PER_SEC = 1000;
  localparam int MS_W       = 10;
  localparam int PERIOD_W   = 16;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNSUP = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SET_HZ = 3'd1,
    ACT_SET_MS = 3'd2,
    ACT_CLOSE  = 3'd3,
    ACT_ARM    = 3'd4,
    ACT_POLL   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WR_PER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic idx_zero;
    logic idx_inc;
    logic rd;
    logic tick_wb;
    logic close_wb;
    logic set_hz;
    logic div_init;
    logic div_step;
    logic set_per;
    logic arm;
    logic poll;
    logic st_unsup;
    logic st_range;
    logic push;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    task_ok;
    logic    hz_bad;
    logic    per_bad;
    logic    idx_last;
    logic    div_last;
    logic    out_free;
  } stat_t;

endpackage

FILE: hw/rtl/ptftd_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module ptftd_ctrl import ptftd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority if (stat_i.action == ACT_TICK) begin
          state_d = ST_READ;
        end else if (!stat_i.task_ok) begin
          state_d = ST_DONE;
        end else begin
          unique case (stat_i.action)
            ACT_SET_MS: state_d = stat_i.per_bad ? ST_DONE : ST_DIV;
            ACT_CLOSE:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (stat_i.action == ACT_TICK && !stat_i.idx_last) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = ST_WR_PER;
        end
      end
      ST_WR_PER: state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.latch = in_valid_i;
      ST_DISPATCH: begin
        priority if (stat_i.action == ACT_TICK) begin
          cmd_o.idx_zero = 1'b1;
        end else if (!stat_i.task_ok) begin
          cmd_o.st_unsup = (stat_i.action != ACT_SET_HZ) && (stat_i.action != ACT_SET_MS)
                        && (stat_i.action != ACT_CLOSE) && (stat_i.action != ACT_ARM)
                        && (stat_i.action != ACT_POLL);
        end else begin
          unique case (stat_i.action)
            ACT_SET_HZ: begin
              cmd_o.st_range = stat_i.hz_bad;
              cmd_o.set_hz   = !stat_i.hz_bad;
            end
            ACT_SET_MS: begin
              cmd_o.st_range = stat_i.per_bad;
              cmd_o.div_init = !stat_i.per_bad;
            end
            ACT_CLOSE: cmd_o.idx_inc = 1'b0;
            ACT_ARM:   cmd_o.arm = 1'b1;
            ACT_POLL:  cmd_o.poll = 1'b1;
            default:   cmd_o.st_unsup = 1'b1;
          endcase
        end
      end
      ST_READ: cmd_o.rd = 1'b1;
      ST_EXEC: begin
        if (stat_i.action == ACT_TICK) begin
          cmd_o.tick_wb = 1'b1;
          cmd_o.idx_inc = !stat_i.idx_last;
        end else begin
          cmd_o.close_wb = 1'b1;
        end
      end
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_WR_PER: cmd_o.set_per = 1'b1;
      ST_DONE:   cmd_o.push = stat_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/ptftd_dp.sv
// Datapath with task storage, tick update, period divider and output register.
module ptftd_dp import ptftd_pkg::*; #(
  parameter int NUM_TASKS    = NUM_TASKS_DEF,
  parameter int BASE_FREQ_HZ = BASE_FREQ_HZ_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  action_i,
  input  logic [2:0]  task_req_i,
  input  logic [31:0] value_i,
  input  logic        out_stall_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  fired_mask_o,
  output logic        event_flag_o
);

  localparam int IW  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int HZW = $clog2(BASE_FREQ_HZ + 1);
  localparam int RW  = HZW + FRAC_BITS;
  localparam int DW  = MS_W + FRAC_BITS;
  localparam int CW  = $clog2(DW);
  localparam logic [RW:0] BaseFixed = (RW+1)'(BASE_FREQ_HZ) << FRAC_BITS;
  localparam logic [DW-1:0] Dividend = {MS_W'(MS_PER_SEC), {FRAC_BITS{1'b0}}};

  logic [2:0]          act_q;
  logic                task_ok_q;
  logic [IW-1:0]       idx_q;
  logic [31:0]         value_q;
  logic [2*RW-1:0]     mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_q;
  logic [NUM_TASKS-1:0] ev_q;
  logic [RW-1:0]       rd_rate_q, rd_acc_q;
  logic [PERIOD_W:0]   rem_q;
  logic [DW-1:0]       quo_q;
  logic [CW-1:0]       cnt_q;
  logic [1:0]          res_status_q;
  logic [7:0]          res_mask_q;
  logic                res_flag_q;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [7:0]          fired_q;
  logic                flag_q;

  logic [PERIOD_W-1:0] period;
  logic [29:0]         per_prod;
  logic [RW:0]         sum;
  logic                fire;
  logic [RW-1:0]       acc_new;
  logic [PERIOD_W:0]   trial;
  logic                q_bit;
  logic                we;
  logic [2*RW-1:0]     wdata;
  logic [7:0]          mask_set;

  assign period   = value_q[PERIOD_W-1:0];
  assign per_prod = 30'(BASE_FREQ_HZ) * 30'(period);
  assign sum      = {1'b0, rd_acc_q} + {1'b0, rd_rate_q};
  assign fire     = (rd_rate_q != '0) && (sum >= BaseFixed);
  assign acc_new  = fire ? RW'(sum - BaseFixed) : RW'(sum);
  assign trial    = {rem_q[PERIOD_W-1:0], quo_q[DW-1]};
  assign q_bit    = (trial >= {1'b0, period});

  assign stat_o.action   = action_e'(act_q);
  assign stat_o.task_ok  = task_ok_q;
  assign stat_o.hz_bad   = value_q > 32'(BASE_FREQ_HZ);
  assign stat_o.per_bad  = (period == '0) || (30'(MS_PER_SEC) > per_prod);
  assign stat_o.idx_last = (idx_q == IW'(NUM_TASKS - 1));
  assign stat_o.div_last = (cnt_q == CW'(DW - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    we    = 1'b0;
    wdata = '0;
    priority if (cmd_i.tick_wb) begin
      we    = (rd_rate_q != '0);
      wdata = {rd_rate_q, acc_new};
    end else if (cmd_i.close_wb) begin
      we    = 1'b1;
      wdata = {{RW{1'b0}}, rd_acc_q};
    end else if (cmd_i.set_hz) begin
      we    = 1'b1;
      wdata = {value_q[HZW-1:0], {FRAC_BITS{1'b0}}, {RW{1'b0}}};
    end else if (cmd_i.set_per) begin
      we    = 1'b1;
      wdata = {RW'(quo_q), {RW{1'b0}}};
    end else begin
      we    = 1'b0;
    end
  end

  always_comb begin
    mask_set = '0;
    for (int i = 0; i < 8; i++) begin
      if (cmd_i.tick_wb && fire && (32'(idx_q) == 32'(i))) begin
        mask_set[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    if (cmd_i.rd) begin
      if (vld_q[idx_q]) begin
        {rd_rate_q, rd_acc_q} <= mem[idx_q];
      end else begin
        {rd_rate_q, rd_acc_q} <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q     <= action_i;
      task_ok_q <= ({29'b0, task_req_i} < 32'(NUM_TASKS));
      idx_q     <= IW'(task_req_i);
      value_q   <= value_i;
    end else if (cmd_i.idx_zero) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= Dividend;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? (trial - {1'b0, period}) : trial;
      quo_q <= {quo_q[DW-2:0], q_bit};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.push) begin
      status_q <= res_status_q;
      fired_q  <= res_mask_q;
      flag_q   <= res_flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      ev_q         <= '0;
      res_status_q <= STAT_OK;
      res_mask_q   <= '0;
      res_flag_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (we) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.tick_wb && fire) begin
        ev_q[idx_q] <= 1'b1;
      end else if (cmd_i.arm) begin
        ev_q[idx_q] <= 1'b0;
      end
      if (cmd_i.latch) begin
        res_status_q <= STAT_OK;
        res_mask_q   <= '0;
        res_flag_q   <= 1'b0;
      end else begin
        if (cmd_i.st_unsup) begin
          res_status_q <= STAT_UNSUP;
        end else if (cmd_i.st_range) begin
          res_status_q <= STAT_RANGE;
        end
        res_mask_q <= res_mask_q | mask_set;
        if (cmd_i.poll) begin
          res_flag_q <= ev_q[idx_q];
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign fired_mask_o = fired_q;
  assign event_flag_o = flag_q;

endmodule

FILE: hw/rtl/per_task_fractional_tick_divider_top.sv
// Top level of the per-task fractional tick divider.
// Each request gets exactly one result. A tick walks all tasks through one storage port, with a
// read state and a write-back state for each task in turn; a period request runs a restoring
// divider one quotient bit a cycle; a close reads and rewrites its entry. One request is in
// work at a time, and a new one is taken while the previous result still waits in the output
// register.
module per_task_fractional_tick_divider_top import ptftd_pkg::*; #(
  parameter int NUM_TASKS    = NUM_TASKS_DEF,
  parameter int BASE_FREQ_HZ = BASE_FREQ_HZ_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  task_req_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  fired_mask_o,
  output logic        event_flag_o
);

  cmd_t  cmd;
  stat_t stat;

  ptftd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (in_stall_o)
  );

  ptftd_dp #(
    .NUM_TASKS    (NUM_TASKS),
    .BASE_FREQ_HZ (BASE_FREQ_HZ),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .task_req_i   (task_req_i),
    .value_i      (value_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .fired_mask_o (fired_mask_o),
    .event_flag_o (event_flag_o)
  );

endmodule

FILE: tb/sv/per_task_fractional_tick_divider_top_tb.sv
// Self-checking testbench for the per-task fractional tick divider: predicted results versus the DUT.
module per_task_fractional_tick_divider_top_tb;
  import ptftd_pkg::*;

  localparam logic [2:0] ACT_RSVD_LO = 3'd6;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;
  localparam logic [63:0] BASE_FIXED = 64'(BASE_FREQ_HZ_DEF) << FRAC_BITS_DEF;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  task_idx;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] fired_mask;
    logic       event_flag;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = '0;
  logic [2:0]  task_req_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  fired_mask_o;
  logic        event_flag_o;

  request_t request_queue[$];
  result_t  awaited_results[$];

  logic [63:0] timer_rate[NUM_TASKS_DEF];
  logic [63:0] timer_phase[NUM_TASKS_DEF];
  logic        timer_event[NUM_TASKS_DEF];

  int unsigned errors = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  result_t     expected;

  per_task_fractional_tick_divider_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .task_req_i   (task_req_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .fired_mask_o (fired_mask_o),
    .event_flag_o (event_flag_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < NUM_TASKS_DEF; i++) begin
      timer_rate[i]  = '0;
      timer_phase[i] = '0;
      timer_event[i] = 1'b0;
    end
  end

  task automatic add_request(input logic [2:0] act, input logic [2:0] idx,
                             input logic [31:0] val);
    request_t r;
    r.action   = act;
    r.task_idx = idx;
    r.value    = val;
    request_queue.push_back(r);
  endtask

  task automatic advance_timers(input logic [2:0] act, input logic [2:0] idx,
                                input logic [31:0] val);
    result_t     r;
    logic [63:0] period;
    r = '0;
    period = 64'(val[15:0]);
    if (act == ACT_TICK) begin
      for (int i = 0; i < NUM_TASKS_DEF; i++) begin
        if (timer_rate[i] != 0) begin
          timer_phase[i] = timer_phase[i] + timer_rate[i];
          if (timer_phase[i] >= BASE_FIXED) begin
            timer_phase[i] = timer_phase[i] - BASE_FIXED;
            timer_event[i] = 1'b1;
            if (i < 8) r.fired_mask[i] = 1'b1;
          end
        end
      end
    end else if (act > ACT_POLL) begin
      r.status = STAT_UNSUP;
    end else if (32'(idx) < NUM_TASKS_DEF) begin
      if (act == ACT_SET_HZ) begin
        if (64'(val) > 64'(BASE_FREQ_HZ_DEF)) begin
          r.status = STAT_RANGE;
        end else begin
          timer_rate[idx]  = 64'(val) << FRAC_BITS_DEF;
          timer_phase[idx] = '0;
        end
      end else if (act == ACT_SET_MS) begin
        if (period == 0 || 64'(MS_PER_SEC) > 64'(BASE_FREQ_HZ_DEF) * period) begin
          r.status = STAT_RANGE;
        end else begin
          timer_rate[idx]  = (64'(MS_PER_SEC) << FRAC_BITS_DEF) / period;
          timer_phase[idx] = '0;
        end
      end else if (act == ACT_CLOSE) begin
        timer_rate[idx] = '0;
      end else if (act == ACT_ARM) begin
        timer_event[idx] = 1'b0;
      end else begin
        r.event_flag = timer_event[idx];
      end
    end
    awaited_results.push_back(r);
  endtask

  task automatic present_next();
    request_t r;
    r = request_queue.pop_front();
    in_valid_i <= 1'b1;
    action_i   <= r.action;
    task_req_i <= r.task_idx;
    value_i    <= r.value;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i   <= '0;
      task_req_i <= '0;
      value_i    <= '0;
      send_wait  <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_timers(action_i, task_req_i, value_i);
        send_gap = send_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        if (send_gap == 0 && request_queue.size() != 0) begin
          present_next();
        end else begin
          in_valid_i <= 1'b0;
          send_wait  <= send_gap;
        end
      end else if (!in_valid_i) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
        end else if (request_queue.size() != 0) begin
          present_next();
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no request pending: status %0d mask %02h flag %0d",
                     $time, status_o, fired_mask_o, event_flag_o);
        end else begin
          expected = awaited_results.pop_front();
          if (status_o !== expected.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: status expected %0d actual %0d",
                       $time, expected.status, status_o);
          end
          if (fired_mask_o !== expected.fired_mask) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: fired_mask expected %02h actual %02h",
                       $time, expected.fired_mask, fired_mask_o);
          end
          if (event_flag_o !== expected.event_flag) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: event_flag expected %0d actual %0d",
                       $time, expected.event_flag, event_flag_o);
          end
        end
        recv_gap = recv_burst ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        out_stall_i <= (recv_gap != 0);
        recv_wait   <= recv_gap;
      end else if (recv_wait != 0) begin
        recv_wait   <= recv_wait - 1;
        out_stall_i <= (recv_wait > 1);
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned r;
    logic [31:0] val;
    logic [15:0] period;

    add_request(ACT_TICK, 3'd0, 32'hFFFF_FFFF);
    add_request(ACT_POLL, 3'd0, 32'd0);
    add_request(ACT_SET_HZ, 3'd0, BASE_FREQ_HZ_DEF);
    add_request(ACT_TICK, 3'd5, 32'd0);
    add_request(ACT_POLL, 3'd0, 32'hFFFF_FFFF);
    add_request(ACT_ARM, 3'd0, 32'd0);
    add_request(ACT_POLL, 3'd0, 32'd0);
    add_request(ACT_SET_HZ, 3'd1, BASE_FREQ_HZ_DEF + 1);
    add_request(ACT_SET_HZ, 3'd2, 32'hFFFF_FFFF);
    add_request(ACT_SET_HZ, 3'd3, 32'd0);
    add_request(ACT_SET_MS, 3'd4, 32'd0);
    add_request(ACT_SET_MS, 3'd5, 32'hFFFF_0000);
    add_request(ACT_SET_MS, 3'd6, 32'd1);
    add_request(ACT_SET_MS, 3'd7, 32'h0000_FFFF);
    add_request(ACT_SET_MS, 3'd1, 32'hABCD_0003);
    add_request(ACT_SET_HZ, 3'd2, 32'd512);
    add_request(ACT_TICK, 3'd0, 32'd0);
    add_request(ACT_TICK, 3'd0, 32'd0);
    add_request(ACT_TICK, 3'd0, 32'd0);
    add_request(ACT_CLOSE, 3'd0, 32'hFFFF_FFFF);
    add_request(ACT_TICK, 3'd0, 32'd0);
    add_request(ACT_POLL, 3'd6, 32'd0);
    add_request(ACT_RSVD_LO, 3'd2, 32'h5555_AAAA);
    add_request(ACT_RSVD_HI, 3'd7, 32'hFFFF_FFFF);
    add_request(ACT_POLL, 3'd1, 32'd0);

    repeat (1850) begin
      pick = $urandom_range(0, 99);
      r = $urandom;
      if (pick < 45) begin
        add_request(ACT_TICK, 3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0) ? r : 32'd0);
      end else if (pick < 55) begin
        val = ($urandom_range(0, 4) == 0) ? r : 32'($urandom_range(0, BASE_FREQ_HZ_DEF));
        add_request(ACT_SET_HZ, 3'($urandom_range(0, 7)), val);
      end else if (pick < 63) begin
        case ($urandom_range(0, 9))
          0:       period = 16'd0;
          1:       period = 16'($urandom);
          2:       period = 16'hFFFF;
          default: period = 16'($urandom_range(1, 50));
        endcase
        val = {($urandom_range(0, 2) == 0) ? r[31:16] : 16'd0, period};
        add_request(ACT_SET_MS, 3'($urandom_range(0, 7)), val);
      end else if (pick < 68) begin
        add_request(ACT_CLOSE, 3'($urandom_range(0, 7)), r);
      end else if (pick < 78) begin
        add_request(ACT_ARM, 3'($urandom_range(0, 7)), r);
      end else if (pick < 95) begin
        add_request(ACT_POLL, 3'($urandom_range(0, 7)), r);
      end else if (pick < 97) begin
        add_request(($urandom_range(0, 1) == 0) ? ACT_RSVD_LO : ACT_RSVD_HI,
                    3'($urandom_range(0, 7)), r);
      end else begin
        add_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), r);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
